// ----- sv/csnm_pkg.sv -----
// ----------------------------------------------------------------------------
// csnm_pkg
// Shared widths, register indexes and item types of the coincident spike
// noise marker.
// ----------------------------------------------------------------------------
`default_nettype none

package csnm_pkg;

	// Field widths
	localparam int STAMP_W = 32;
	localparam int CHAN_W  = 16;
	localparam int CODE_W  = 8;
	localparam int THR_W   = 6;
	localparam int PKT_W   = CHAN_W + CODE_W;

	// Default buffer depth
	localparam int RUN_DEPTH_DEF = 64;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_CODE    = 1'd1;

	// Reset values
	localparam logic [THR_W-1:0]   THR_RESET   = '0;
	localparam logic [CODE_W-1:0]  NOISE_RESET = '1;
	localparam logic [STAMP_W-1:0] STAMP_NONE  = '1;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [CHAN_W-1:0]  channel_id;
		logic [CODE_W-1:0]  unit_in;
		logic               end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [STAMP_W-1:0] stamp_out;
		logic [CHAN_W-1:0]  channel_out;
		logic [CODE_W-1:0]  unit_out;
		logic               last_of_run;
	} out_item_t;

endpackage

`default_nettype wire

// ----- sv/csnm_out_reg.sv -----
// ----------------------------------------------------------------------------
// csnm_out_reg
// Output register of the result channel: holds one item until the
// downstream side takes it and reports when a new item may be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module csnm_out_reg (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 load,
	input  csnm_pkg::out_item_t item,
	output logic                free,
	output logic                out_valid,
	input  wire                 out_stall,
	output csnm_pkg::out_item_t out_data
);
	import csnm_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// Slot is free when empty or being taken this cycle
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= item;
		end
	end

endmodule

`default_nettype wire

// ----- sv/coincident_spike_noise_marker_core.sv -----
// An item that does not close a run is taken and emits nothing; an item
// that closes a run of n packets starts emission: each packet is read from
// the packet memory into a read register and then into the output register,
// one result per cycle while the output does not stall. Input stalls while a
// run is emitted (one memory read port). Reset clears control state only;
// the packet memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// coincident_spike_noise_marker_core
// Holds runs of spike packets with a common timestamp in a packet memory and
// emits each run, marked with the noise code when too long (flush: only on overflow).
// ----------------------------------------------------------------------------
`default_nettype none

module coincident_spike_noise_marker_core #(
	parameter int RUN_DEPTH = csnm_pkg::RUN_DEPTH_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [csnm_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire  [csnm_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  csnm_pkg::in_item_t                     in_data,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output csnm_pkg::out_item_t                    out_data
);
	import csnm_pkg::*;

	localparam int CW   = $clog2(RUN_DEPTH + 1);
	localparam int AW   = $clog2(RUN_DEPTH);
	localparam int CMPW = (CW > THR_W) ? CW : THR_W;
	localparam logic [CW-1:0] CNT_FULL = CW'(RUN_DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	// Control state
	state_t             state_q;
	logic [CW-1:0]      cnt_q;
	logic [STAMP_W-1:0] held_stamp_q;
	logic               run_marked_q;
	logic [THR_W-1:0]   thr_q;
	logic [CODE_W-1:0]  noise_q;
	logic               pend_q;
	logic [CW-1:0]      iss_q;
	logic               rd_full_q;

	// Emission payload
	logic [PKT_W-1:0]   pend_pkt_q;
	logic [STAMP_W-1:0] emit_stamp_q;
	logic               emit_mark_q;
	logic               rd_last_q;
	logic [PKT_W-1:0]   mem_rd_q;

	// Packet memory
	logic [PKT_W-1:0]   mem [RUN_DEPTH];

	logic               acc;
	logic               empty;
	logic               same;
	logic               full;
	logic               do_emit;
	logic               over_thr;
	logic [PKT_W-1:0]   in_pkt;
	logic               out_free;
	logic               load;
	logic               issue;
	logic               done;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [PKT_W-1:0]   mem_wdata;
	out_item_t          item;

	// Accept only while idle
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;

	// Classify the incoming item against the held run
	assign empty    = (cnt_q == '0);
	assign same     = (in_data.stamp == held_stamp_q);
	assign full     = (cnt_q == CNT_FULL);
	assign do_emit  = !empty && (!same || full);
	assign over_thr = CMPW'(cnt_q) > CMPW'(thr_q);
	assign in_pkt   = {in_data.channel_id, in_data.unit_in};

	// Emission read pipeline
	assign load  = (state_q == ST_EMIT) && rd_full_q && out_free;
	assign issue = (state_q == ST_EMIT) && (iss_q != cnt_q) && (!rd_full_q || load);
	assign done  = (state_q == ST_EMIT) && (iss_q == cnt_q) && !rd_full_q;

	// Select the memory write: store a packet or restart with the pending one
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = in_pkt;
		if (acc && !in_data.end_of_stream && !do_emit) begin
			mem_we = 1'b1;
		end else if (done && pend_q) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = pend_pkt_q;
		end
	end

	// Write and read the packet memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (issue) begin
			mem_rd_q  <= mem[iss_q[AW-1:0]];
			rd_last_q <= (iss_q == cnt_q - CNT_ONE);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			noise_q <= NOISE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RUN_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				REG_NOISE_CODE:    noise_q <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Run control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			held_stamp_q <= STAMP_NONE;
			run_marked_q <= 1'b0;
			pend_q       <= 1'b0;
			iss_q        <= '0;
			rd_full_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					iss_q <= '0;
					if (acc) begin
						if (in_data.end_of_stream) begin
							// Flush the held run
							run_marked_q <= 1'b0;
							held_stamp_q <= STAMP_NONE;
							pend_q       <= 1'b0;
							if (!empty) begin
								state_q <= ST_EMIT;
							end
						end else begin
							held_stamp_q <= in_data.stamp;
							if (do_emit) begin
								// Close the run, hold the new packet aside
								state_q      <= ST_EMIT;
								pend_q       <= 1'b1;
								run_marked_q <= same;
							end else begin
								cnt_q <= cnt_q + CNT_ONE;
								if (empty) begin
									run_marked_q <= 1'b0;
								end
							end
						end
					end
				end
				ST_EMIT: begin
					if (issue) begin
						iss_q     <= iss_q + CNT_ONE;
						rd_full_q <= 1'b1;
					end else if (load) begin
						rd_full_q <= 1'b0;
					end
					if (done) begin
						state_q <= ST_IDLE;
						cnt_q   <= pend_q ? CNT_ONE : '0;
						pend_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Latch emission context when a run closes
	always_ff @(posedge clk) begin
		if (acc && (in_data.end_of_stream || do_emit)) begin
			emit_stamp_q <= held_stamp_q;
			pend_pkt_q   <= in_pkt;
			if (in_data.end_of_stream) begin
				emit_mark_q <= run_marked_q;
			end else begin
				emit_mark_q <= same || run_marked_q || over_thr;
			end
		end
	end

	// Form the result item
	always_comb begin
		item.stamp_out   = emit_stamp_q;
		item.channel_out = mem_rd_q[PKT_W-1:CODE_W];
		item.unit_out    = emit_mark_q ? noise_q : mem_rd_q[CODE_W-1:0];
		item.last_of_run = rd_last_q;
	end

	csnm_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.item      (item),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- bench/coincident_spike_noise_marker_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coincident_spike_noise_marker_core_test
// Drives spike packets into the noise marker and tracks its run buffer in a
// local predictor. Each emitted packet is checked field by field against the
// oldest predicted packet. Directed runs cover the register reset values, the
// field extremes, the threshold boundary, the full buffer and end of stream.
// Random runs under several register settings, random idling on both sides,
// a long output hold-off and a sender pause follow.
// ----------------------------------------------------------------------------

module coincident_spike_noise_marker_core_test;
	import csnm_pkg::*;

	localparam int RUN_DEPTH      = RUN_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 30;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	// Predictor state
	logic [STAMP_W-1:0] run_stamp = STAMP_NONE;
	int                 run_len = 0;
	logic               run_overflowed = 1'b0;
	logic [CHAN_W-1:0]  run_chan [RUN_DEPTH];
	logic [CODE_W-1:0]  run_unit [RUN_DEPTH];
	logic [THR_W-1:0]   thr_reg = THR_RESET;
	logic [CODE_W-1:0]  noise_reg = NOISE_RESET;
	out_item_t          pending_packets [$];

	int   mismatches = 0;
	int   idle_cycles = 0;
	logic tx_quiet = 1'b0;
	logic rx_quiet = 1'b0;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;
	int   rx_left = 0;
	logic rx_stalling = 1'b0;

	coincident_spike_noise_marker_core #(
		.RUN_DEPTH(RUN_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #4 clk = ~clk;

	// Idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < 40)
			$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Emit the held run into the expected packets and empty the buffer
	function automatic void release_run(input logic as_noise);
		out_item_t r;
		for (int k = 0; k < run_len; k++) begin
			r.stamp_out   = run_stamp;
			r.channel_out = run_chan[k];
			r.unit_out    = as_noise ? noise_reg : run_unit[k];
			r.last_of_run = (k == run_len - 1);
			pending_packets.push_back(r);
		end
		run_len = 0;
	endfunction

	// Advance the predicted buffer by one accepted item
	function automatic void mark_packet(input in_item_t it);
		if (it.end_of_stream) begin
			release_run(run_overflowed);
			run_overflowed = 1'b0;
			run_stamp = STAMP_NONE;
			return;
		end
		if (run_len == 0) begin
			run_overflowed = 1'b0;
		end else if (it.stamp == run_stamp) begin
			if (run_len >= RUN_DEPTH) begin
				run_overflowed = 1'b1;
				release_run(1'b1);
			end
		end else begin
			release_run(run_overflowed || (run_len > int'(thr_reg)));
			run_overflowed = 1'b0;
		end
		run_stamp = it.stamp;
		if (run_len < RUN_DEPTH) begin
			run_chan[run_len] = it.channel_id;
			run_unit[run_len] = it.unit_in;
			run_len++;
		end
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input in_item_t it);
		int gap;
		gap = 0;
		if (!tx_quiet && $urandom_range(0, 9) >= 5)
			gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mark_packet(it);
	endtask

	task automatic send_pkt(input logic [STAMP_W-1:0] stamp, input logic [CHAN_W-1:0] chan,
			input logic [CODE_W-1:0] unit);
		in_item_t it;
		it.stamp         = stamp;
		it.channel_id    = chan;
		it.unit_in       = unit;
		it.end_of_stream = 1'b0;
		send_item(it);
	endtask

	task automatic send_run(input logic [STAMP_W-1:0] stamp, input int len);
		for (int k = 0; k < len; k++)
			send_pkt(stamp, CHAN_W'($urandom_range(0, 65535)),
				CODE_W'($urandom_range(0, 255)));
	endtask

	// End of stream with garbage in the ignored fields
	task automatic send_eos();
		in_item_t it;
		it.stamp         = $urandom;
		it.channel_id    = CHAN_W'($urandom_range(0, 65535));
		it.unit_in       = CODE_W'($urandom_range(0, 255));
		it.end_of_stream = 1'b1;
		send_item(it);
	endtask

	// Drop valid and wait until every expected packet has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_packets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_RUN_THRESHOLD: thr_reg = val[THR_W-1:0];
			REG_NOISE_CODE:    noise_reg = val[CODE_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [CFG_DATA_W-1:0] thr_data,
			input logic [CODE_W-1:0] code);
		wait_drained();
		write_reg(REG_RUN_THRESHOLD, thr_data);
		write_reg(REG_NOISE_CODE, code);
	endtask

	function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] prev);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom;
		else if (r == 1)
			return prev - 1;
		else if (r == 2)
			return STAMP_NONE;
		return prev + $urandom_range(1, 50);
	endfunction

	// Reset values: threshold 0 marks any closed run, noise code all ones
	task automatic test_reset_values();
		send_eos();
		send_pkt(STAMP_NONE, 16'h0000, 8'h00);
		send_pkt(32'h0000_0000, 16'hFFFF, 8'hFF);
		send_eos();
		send_eos();
	endtask

	task automatic test_field_extremes();
		set_config(8'd63, 8'h00);
		send_pkt(32'h0000_0000, 16'h0000, 8'h00);
		send_pkt(32'h0000_0000, 16'hFFFF, 8'hFF);
		send_pkt(32'h0000_0000, 16'hAAAA, 8'h55);
		send_pkt(32'h0000_0000, 16'h5555, 8'hAA);
		send_pkt(STAMP_NONE, 16'h1234, 8'h80);
		send_pkt(32'h8000_0000, 16'h8000, 8'h01);
		send_pkt(32'h7FFF_FFFF, 16'h0001, 8'h7F);
		send_eos();
	endtask

	// Runs just at and just over the threshold; end of stream skips the test
	task automatic test_threshold_boundary();
		set_config(8'd2, 8'h3C);
		send_run(32'd10, 2);
		send_run(32'd11, 3);
		send_run(32'd12, 3);
		send_eos();
	endtask

	// Fill the buffer exactly, then overflow it twice
	task automatic test_full_buffer();
		set_config(8'd63, 8'hA5);
		send_run(32'h0001_0000, RUN_DEPTH);
		send_run(32'h0001_0001, RUN_DEPTH + 2);
		send_run(32'h0001_0002, RUN_DEPTH + 1);
		send_eos();
		send_eos();
	endtask

	// Hold the output off while the sender keeps offering items
	task automatic test_receiver_hold();
		logic [STAMP_W-1:0] stamp;
		set_config(8'd3, 8'hE1);
		stamp = $urandom;
		tx_quiet = 1'b1;
		hold_toggle = ~hold_toggle;
		for (int k = 0; k < 14; k++) begin
			stamp = stamp + $urandom_range(1, 9);
			send_run(stamp, $urandom_range(1, 6));
		end
		send_eos();
		tx_quiet = 1'b0;
		wait_drained();
	endtask

	// Pause the sender with a run held, then continue that run
	task automatic test_sender_pause();
		logic [STAMP_W-1:0] stamp;
		stamp = $urandom;
		rx_quiet = 1'b1;
		send_run(stamp, 3);
		send_run(stamp + 1, 2);
		wait_drained();
		send_run(stamp + 1, 3);
		send_run(stamp + 2, 1);
		wait_drained();
		rx_quiet = 1'b0;
		send_eos();
	endtask

	// Well-formed runs with random content, plus stray stamps and flushes
	task automatic test_random_runs();
		logic [STAMP_W-1:0]    stamp;
		logic [CFG_DATA_W-1:0] thr_data;
		logic [CODE_W-1:0]     code;
		int                    sent;
		int                    len;
		int                    r;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			thr_data = CFG_DATA_W'($urandom_range(0, 255));
			code = CODE_W'($urandom_range(0, 255));
			if (phase == 0)
				thr_data[THR_W-1:0] = '0;
			else if (phase == 1)
				thr_data[THR_W-1:0] = '1;
			if (phase == 2)
				code = '0;
			else if (phase == 3)
				code = '1;
			set_config(thr_data, code);
			stamp = $urandom;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				r = $urandom_range(0, 29);
				if (r == 0) begin
					send_eos();
					sent++;
				end else begin
					if (r < 21)
						len = $urandom_range(1, 4);
					else if (r < 29)
						len = $urandom_range(1, int'(thr_reg) + 2);
					else
						len = $urandom_range(RUN_DEPTH - 4, RUN_DEPTH + 6);
					stamp = next_stamp(stamp);
					send_run(stamp, len);
					sent += len;
				end
			end
			send_eos();
		end
	endtask

	// Check each accepted packet and pick the next output stall
	always @(posedge clk) begin : rx_side
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_packets.size() == 0) begin
				report_mismatch($sformatf("unexpected packet stamp %h channel %h unit %h",
					out_data.stamp_out, out_data.channel_out, out_data.unit_out));
			end else begin
				want = pending_packets.pop_front();
				if (out_data.stamp_out !== want.stamp_out)
					report_mismatch($sformatf("stamp_out %h, expected %h",
						out_data.stamp_out, want.stamp_out));
				if (out_data.channel_out !== want.channel_out)
					report_mismatch($sformatf("channel_out %h, expected %h",
						out_data.channel_out, want.channel_out));
				if (out_data.unit_out !== want.unit_out)
					report_mismatch($sformatf("unit_out %h, expected %h",
						out_data.unit_out, want.unit_out));
				if (out_data.last_of_run !== want.last_of_run)
					report_mismatch($sformatf("last_of_run %b, expected %b",
						out_data.last_of_run, want.last_of_run));
			end
		end
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (rx_quiet) begin
			out_stall <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_stalling = ($urandom_range(0, 3) == 0);
				rx_left = rx_stalling ? pick_gap() : $urandom_range(1, 20);
			end
			rx_left--;
			out_stall <= rx_stalling;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_threshold_boundary();
		test_full_buffer();
		test_receiver_hold();
		test_sender_pause();
		test_random_runs();
		wait_drained();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
